FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/bsfl_pkg.sv
// Package: types and constants of the bindless slot allocator.
package bsfl_pkg;

  localparam int NUM_SETS      = 2;
  localparam int SET_W         = 1;
  localparam int SLOTS_DEFAULT = 1024;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STAT_BUMP      = 2'd0;
  localparam logic [1:0] STAT_FREE      = 2'd1;
  localparam logic [1:0] STAT_RELEASE   = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

  localparam logic CFG_LIMIT_STORAGE = 1'b0;
  localparam logic CFG_LIMIT_ACCEL   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

FILE: rtl/core/bindless_slot_free_list_allocator_core.sv
// Top level: two-set slot allocator, bump counters plus free lists in a link RAM.
//
// Usage:
//   Input: drive start with in_operation, in_set_select, in_slot_index and
//   in_handle_valid; the item transfers on a clock edge with start high and
//   busy low. Reserve hands out a slot (bump, then free list once the set's
//   limit is reached); a valid release pushes a slot onto its set's free list.
//   Result: out_valid is high for one cycle with out_granted_slot,
//   out_granted_set and out_status; the result transfers at the end of that
//   cycle. The receiver cannot stall; there is no backpressure.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_wdata write the two
//   set limits; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   Busy blocks new items during execute. The accept cycle issues the link
//   RAM read of the set's free-list head; the next cycle uses the read data,
//   updates the set state and writes the RAM. The result strobes the cycle
//   after that, and a new item may transfer on the edge ending that cycle.
// Reset:
//   Synchronous on rst_n low: counters cleared, lists empty, limits set to
//   the set depth. The link RAM needs no clearing pass.
module bindless_slot_free_list_allocator_core #(
  parameter int SLOTS_PER_SET = bsfl_pkg::SLOTS_DEFAULT,
  localparam int SLOT_W  = $clog2(SLOTS_PER_SET),
  localparam int COUNT_W = $clog2(SLOTS_PER_SET + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [bsfl_pkg::SET_W-1:0] in_set_select,
  input  logic [SLOT_W-1:0]         in_slot_index,
  input  logic                      in_handle_valid,
  output logic                      out_valid,
  output logic [SLOT_W-1:0]         out_granted_slot,
  output logic [bsfl_pkg::SET_W-1:0] out_granted_set,
  output logic [1:0]                out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [COUNT_W-1:0]        cfg_wdata
);

  import bsfl_pkg::*;

  `include "assert_macros.svh"

  localparam int ADDR_W = SET_W + SLOT_W;
  localparam logic [COUNT_W-1:0] END_MARK = COUNT_W'(SLOTS_PER_SET);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] limit_storage_r, limit_accel_r;
  logic [COUNT_W-1:0] bump_r     [NUM_SETS];
  logic [COUNT_W-1:0] bump_nxt   [NUM_SETS];
  logic               nonempty_r [NUM_SETS];
  logic               nonempty_nxt [NUM_SETS];
  logic [SLOT_W-1:0]  head_r     [NUM_SETS];
  logic [SLOT_W-1:0]  head_nxt   [NUM_SETS];

  logic               op_r, hvalid_r;
  logic [SET_W-1:0]   set_r;
  logic [SLOT_W-1:0]  slot_r;

  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [SET_W-1:0]   out_set_r;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               in_xfer;
  logic               exec;
  logic [COUNT_W-1:0] limit;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] rd_data;

  assign in_xfer   = start && !busy;
  assign cfg_ready = 1'b1;

  // State machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State machine: outputs
  always_comb begin
    unique case (state_r)
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_storage_r <= END_MARK;
      limit_accel_r   <= END_MARK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIMIT_STORAGE: limit_storage_r <= cfg_wdata;
        CFG_LIMIT_ACCEL:   limit_accel_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item capture at transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_operation;
      set_r    <= in_set_select;
      slot_r   <= in_slot_index;
      hvalid_r <= in_handle_valid;
    end
  end

  // Link read of the current head is issued in the accept cycle
  assign rd_addr = {in_set_select, head_r[in_set_select]};

  bsfl_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_SETS << SLOT_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign limit = (set_r == SET_W'(1)) ? limit_accel_r : limit_storage_r;

  // Execute: read-modify-write of the selected set
  always_comb begin
    bump_nxt       = bump_r;
    nonempty_nxt   = nonempty_r;
    head_nxt       = head_r;
    out_slot_nxt   = '0;
    out_status_nxt = STAT_RELEASE;
    wr_en          = 1'b0;
    wr_addr        = {set_r, slot_r};
    wr_data        = nonempty_r[set_r] ? {1'b0, head_r[set_r]} : END_MARK;
    if (exec) begin
      if (op_r == OP_RESERVE) begin
        if (nonempty_r[set_r] && (bump_r[set_r] >= limit)) begin
          out_slot_nxt   = head_r[set_r];
          out_status_nxt = STAT_FREE;
          if (rd_data >= END_MARK) begin
            nonempty_nxt[set_r] = 1'b0;
          end else begin
            head_nxt[set_r] = rd_data[SLOT_W-1:0];
          end
        end else if (bump_r[set_r] < END_MARK) begin
          out_slot_nxt    = bump_r[set_r][SLOT_W-1:0];
          out_status_nxt  = STAT_BUMP;
          bump_nxt[set_r] = COUNT_W'(bump_r[set_r] + 1'b1);
        end else begin
          out_status_nxt = STAT_EXHAUSTED;
        end
      end else if (hvalid_r && ({1'b0, slot_r} < END_MARK)) begin
        wr_en               = 1'b1;
        head_nxt[set_r]     = slot_r;
        nonempty_nxt[set_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        bump_r[i]     <= '0;
        nonempty_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      bump_r      <= bump_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= exec;
    end
  end

  // Heads and result payload carry no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (exec) begin
      out_slot_r   <= out_slot_nxt;
      out_set_r    <= set_r;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_granted_set  = out_set_r;
  assign out_status       = out_status_r;

  `ASSERT_NEXT(a_xfer_execs, clk, rst_n, in_xfer, busy)
  `ASSERT_NEXT(a_exec_strobes, clk, rst_n, busy, out_valid && !busy)
  `ASSERT_IMPL(a_link_wr_in_exec, clk, rst_n, wr_en, exec && (op_r == OP_RELEASE))
  `ASSERT_IMPL(a_bump_bounded, clk, rst_n, 1'b1,
               (bump_r[0] <= END_MARK) && (bump_r[1] <= END_MARK))
  `ASSERT_IMPL(a_no_grant_zero, clk, rst_n,
               out_valid && (out_status == STAT_RELEASE || out_status == STAT_EXHAUSTED),
               out_granted_slot == '0)

endmodule

FILE: rtl/core/bsfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: bench/bsfl_grant_checker.sv
// Checker for the slot allocator: predicts each grant and compares it with the result port.
`timescale 1ns / 100ps

module bsfl_grant_checker #(
  parameter int SLOTS_PER_SET = bsfl_pkg::SLOTS_DEFAULT,
  localparam int SLOT_W  = $clog2(SLOTS_PER_SET),
  localparam int COUNT_W = $clog2(SLOTS_PER_SET + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_operation,
  input  logic [bsfl_pkg::SET_W-1:0] in_set_select,
  input  logic [SLOT_W-1:0]          in_slot_index,
  input  logic                       in_handle_valid,
  input  logic                       out_valid,
  input  logic [SLOT_W-1:0]          out_granted_slot,
  input  logic [bsfl_pkg::SET_W-1:0] out_granted_set,
  input  logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [COUNT_W-1:0]         cfg_wdata,
  output int                         pending,
  output int                         fail_count
);
  import bsfl_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SET_W-1:0]  gset;
    logic [1:0]        status;
  } grant_t;

  grant_t             grant_q[$];
  logic [COUNT_W-1:0] limit_r  [NUM_SETS];
  logic [COUNT_W-1:0] bump_r   [NUM_SETS];
  logic               list_live[NUM_SETS];
  logic [SLOT_W-1:0]  head_r   [NUM_SETS];
  logic [COUNT_W-1:0] link_mem [NUM_SETS][SLOTS_PER_SET];
  int                 errors = 0;

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Advances the allocator state by one item and returns the grant it yields.
  function automatic grant_t predict_grant(logic op, logic [SET_W-1:0] s,
                                           logic [SLOT_W-1:0] slot, logic hv);
    grant_t             g;
    logic [COUNT_W-1:0] nxt;
    g.slot   = '0;
    g.gset   = s;
    g.status = STAT_RELEASE;
    if (op == OP_RESERVE) begin
      if (list_live[s] && bump_r[s] >= limit_r[s]) begin
        nxt      = link_mem[s][head_r[s]];
        g.slot   = head_r[s];
        g.status = STAT_FREE;
        // link value at or past the depth marks the tail
        if (nxt >= COUNT_W'(SLOTS_PER_SET)) begin
          list_live[s] = 1'b0;
        end else begin
          head_r[s] = nxt[SLOT_W-1:0];
        end
      end else if (bump_r[s] < COUNT_W'(SLOTS_PER_SET)) begin
        g.slot    = bump_r[s][SLOT_W-1:0];
        bump_r[s] = bump_r[s] + 1'b1;
        g.status  = STAT_BUMP;
      end else begin
        g.status = STAT_EXHAUSTED;
      end
    end else if (hv && int'(slot) < SLOTS_PER_SET) begin
      link_mem[s][slot] = list_live[s] ? COUNT_W'(head_r[s]) : COUNT_W'(SLOTS_PER_SET);
      head_r[s]         = slot;
      list_live[s]      = 1'b1;
    end
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    grant_t fresh;
    if (!rst_n) begin
      grant_q.delete();
      for (int s = 0; s < NUM_SETS; s++) begin
        limit_r[s]   = COUNT_W'(SLOTS_PER_SET);
        bump_r[s]    = '0;
        list_live[s] = 1'b0;
        head_r[s]    = '0;
        for (int i = 0; i < SLOTS_PER_SET; i++) link_mem[s][i] = '0;
      end
    end else begin
      // result first: a new item may transfer on the edge that ends a result
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("result with none pending, status", out_status, -1);
        end else begin
          want = grant_q.pop_front();
          if (out_granted_slot !== want.slot)
            flag_mismatch("granted_slot", out_granted_slot, want.slot);
          if (out_granted_set !== want.gset)
            flag_mismatch("granted_set", out_granted_set, want.gset);
          if (out_status !== want.status)
            flag_mismatch("status", out_status, want.status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIMIT_STORAGE: limit_r[0] = cfg_wdata;
          CFG_LIMIT_ACCEL:   limit_r[1] = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        fresh   = predict_grant(in_operation, in_set_select, in_slot_index, in_handle_valid);
        grant_q = {grant_q, fresh};
      end
    end
    pending    <= grant_q.size();
    fail_count <= errors;
  end

endmodule

FILE: bench/tb_bindless_slot_free_list_allocator_core.sv
// Testbench top: drives reserve/release traffic and limit writes into the slot allocator.
`timescale 1ns / 100ps

module tb_bindless_slot_free_list_allocator_core;
  import bsfl_pkg::*;

  localparam int SLOTS       = SLOTS_DEFAULT;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int COUNT_W     = $clog2(SLOTS + 1);
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [SET_W-1:0]   SET_STORAGE = 1'b0;
  localparam logic [SET_W-1:0]   SET_ACCEL   = 1'b1;
  localparam logic [COUNT_W-1:0] LIMIT_MAX   = '1;
  localparam logic [COUNT_W-1:0] LIMIT_DEPTH = COUNT_W'(SLOTS);

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic               in_operation    = OP_RESERVE;
  logic [SET_W-1:0]   in_set_select   = SET_STORAGE;
  logic [SLOT_W-1:0]  in_slot_index   = '0;
  logic               in_handle_valid = 1'b0;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_granted_slot;
  logic [SET_W-1:0]   out_granted_set;
  logic [1:0]         out_status;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic               cfg_index       = CFG_LIMIT_STORAGE;
  logic [COUNT_W-1:0] cfg_wdata       = '0;
  int                 pending;
  int                 fail_count;
  int                 idle_pct        = 0;

  bindless_slot_free_list_allocator_core #(.SLOTS_PER_SET(SLOTS)) dut (.*);

  bsfl_grant_checker #(.SLOTS_PER_SET(SLOTS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // start stays high across back-to-back items; it drops only for a gap
  task automatic put_item(logic op, logic [SET_W-1:0] s, logic [SLOT_W-1:0] slot, logic hv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_set_select   <= s;
    in_slot_index   <= slot;
    in_handle_valid <= hv;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(logic idx, logic [COUNT_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // releases mostly hit low slots so they land on slots the bump counter has handed out
  task automatic run_mix(int count, int rsv_pct, int accel_pct);
    logic              op;
    logic              hv;
    logic [SET_W-1:0]  s;
    logic [SLOT_W-1:0] slot;
    repeat (count) begin
      op   = ($urandom_range(99) < rsv_pct) ? OP_RESERVE : OP_RELEASE;
      s    = ($urandom_range(99) < accel_pct) ? SET_ACCEL : SET_STORAGE;
      slot = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(63)) : SLOT_W'($urandom);
      hv   = ($urandom_range(99) < 85);
      put_item(op, s, slot, hv);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: bumping only
    put_item(OP_RESERVE, SET_STORAGE, '1, 1'b0);
    put_item(OP_RESERVE, SET_ACCEL, '0, 1'b1);
    put_item(OP_RELEASE, SET_STORAGE, SLOT_W'(5), 1'b0);
    put_item(OP_RELEASE, SET_STORAGE, '1, 1'b1);
    put_item(OP_RELEASE, SET_STORAGE, '0, 1'b1);
    put_item(OP_RESERVE, SET_STORAGE, '0, 1'b0);
    put_item(OP_RELEASE, SET_ACCEL, SLOT_W'(512), 1'b1);
    put_item(OP_RELEASE, SET_ACCEL, SLOT_W'(512), 1'b1);
    // zero limits: reuse whenever a list holds something
    write_limit(CFG_LIMIT_STORAGE, '0);
    write_limit(CFG_LIMIT_ACCEL, '0);
    put_item(OP_RESERVE, SET_STORAGE, '0, 1'b0);
    put_item(OP_RESERVE, SET_STORAGE, '1, 1'b1);
    put_item(OP_RESERVE, SET_STORAGE, '0, 1'b0);
    put_item(OP_RESERVE, SET_ACCEL, '0, 1'b0);
    put_item(OP_RESERVE, SET_ACCEL, '0, 1'b0);
    put_item(OP_RESERVE, SET_ACCEL, '0, 1'b0);
    put_item(OP_RELEASE, SET_ACCEL, '1, 1'b0);

    idle_pct = 6;
    write_limit(CFG_LIMIT_STORAGE, COUNT_W'($urandom_range(32)));
    write_limit(CFG_LIMIT_ACCEL, COUNT_W'($urandom_range(32)));
    run_mix(130, 55, 50);

    idle_pct = 80;
    write_limit(CFG_LIMIT_STORAGE, LIMIT_DEPTH);
    write_limit(CFG_LIMIT_ACCEL, COUNT_W'($urandom_range(16)));
    run_mix(120, 60, 50);

    idle_pct = 0;
    write_limit(CFG_LIMIT_STORAGE, COUNT_W'($urandom_range(8)));
    write_limit(CFG_LIMIT_ACCEL, COUNT_W'($urandom_range(8)));
    run_mix(80, 50, 50);
    drain();
    run_mix(80, 50, 50);

    // limit above the depth: set 1 keeps bumping and never reuses
    idle_pct = 6;
    write_limit(CFG_LIMIT_ACCEL, LIMIT_MAX);
    run_mix(50, 85, 100);
    // limit at the depth: freed slots stay parked while the counter is below it
    write_limit(CFG_LIMIT_ACCEL, LIMIT_DEPTH);
    run_mix(40, 70, 100);

    idle_pct = 0;
    write_limit(CFG_LIMIT_STORAGE, LIMIT_MAX);
    run_mix(40, 60, 50);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bsfl_pkg.sv
rtl/core/bsfl_ram.sv
rtl/core/bindless_slot_free_list_allocator_core.sv
bench/bsfl_grant_checker.sv
bench/tb_bindless_slot_free_list_allocator_core.sv
